/* rtl/pis_pkg.sv */
// Shared types, codes and fixed-point helpers of the particle integrator.
// No dependencies; imported by pis_mul, pis_core and the top level.
package pis_pkg;

    typedef logic signed [31:0] t_word;
    typedef logic signed [32:0] t_opnd;
    typedef logic signed [49:0] t_rnd;
    typedef logic signed [35:0] t_sum;

    localparam logic [1:0] METH_EULER   = 2'd0;
    localparam logic [1:0] METH_SEMI    = 2'd1;
    localparam logic [1:0] METH_VERLET  = 2'd2;

    localparam logic [1:0] KIND_STEP     = 2'd0;
    localparam logic [1:0] KIND_LOAD_POS = 2'd1;
    localparam logic [1:0] KIND_LOAD_VEL = 2'd2;

    localparam logic [1:0] CFG_METHOD    = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP = 2'd1;
    localparam logic [1:0] CFG_INV_MASS  = 2'd2;
    localparam logic [1:0] CFG_INV_DT    = 2'd3;

    localparam t_opnd COEF_A = 33'sd131065;
    localparam t_opnd COEF_B = 33'sd65529;

    typedef struct packed {
        logic [1:0]  method;
        logic [16:0] time_step;
        logic [23:0] inverse_mass;
        logic [30:0] inverse_time_step;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sts;

    function automatic t_rnd f_ext32(input t_word x);
        return {{18{x[31]}}, x};
    endfunction

    function automatic t_rnd f_ext36(input t_sum x);
        return {{14{x[35]}}, x};
    endfunction

    function automatic t_word f_sat(input t_rnd v);
        t_word r;
        if (v > 50'sh0_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -50'sh0_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/particle_integrator_step_top.sv */
// Top level of the particle integrator: configuration registers, input and
// output handshakes, result register. Depends on pis_pkg and pis_core.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_kind, i_value_x/y/z
//  out     | output    | o_out_valid / i_out_stall  | o_position_*, o_velocity_*
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// Each product on the shared multiplier passes through an issue state and a
// write-back state; loads use no product, while Euler and damped Verlet steps do.
// Only one item is in flight; o_in_stall is high from acceptance until its
// result enters the output register, which a new item may follow while it waits.
// A stalled output holds the finished item in the core until the register frees.
// Reset is synchronous and active low: state vectors clear, Verlet start flag sets.
module particle_integrator_step_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_position_x,
    output logic signed [31:0] o_position_y,
    output logic signed [31:0] o_position_z,
    output logic signed [31:0] o_velocity_x,
    output logic signed [31:0] o_velocity_y,
    output logic signed [31:0] o_velocity_z,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    import pis_pkg::*;

    t_cfg  r_cfg;
    logic  r_out_valid;
    t_word r_out_pos [3];
    t_word r_out_vel [3];

    t_sts  w_sts;
    t_word w_val [3];
    t_word w_pos [3];
    t_word w_vel [3];
    logic  w_in_acc;
    logic  w_out_free;

    assign w_val[0]   = i_value_x;
    assign w_val[1]   = i_value_y;
    assign w_val[2]   = i_value_z;
    assign o_in_stall = w_sts.busy;
    assign w_in_acc   = i_in_valid && !w_sts.busy;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.method            <= METH_SEMI;
            r_cfg.time_step         <= 17'd655;
            r_cfg.inverse_mass      <= 24'd65536;
            r_cfg.inverse_time_step <= 31'd6553600;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_METHOD:    r_cfg.method            <= i_cfg_data[1:0];
                CFG_TIME_STEP: r_cfg.time_step         <= i_cfg_data[16:0];
                CFG_INV_MASS:  r_cfg.inverse_mass      <= i_cfg_data[23:0];
                CFG_INV_DT:    r_cfg.inverse_time_step <= i_cfg_data;
            endcase
        end
    end

    pis_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_kind     (i_kind),
        .i_val      (w_val),
        .i_cfg      (r_cfg),
        .i_out_free (w_out_free),
        .o_sts      (w_sts),
        .o_pos      (w_pos),
        .o_vel      (w_vel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.done) begin
            for (int k = 0; k < 3; k++) begin
                r_out_pos[k] <= w_pos[k];
                r_out_vel[k] <= w_vel[k];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_position_x = r_out_pos[0];
    assign o_position_y = r_out_pos[1];
    assign o_position_z = r_out_pos[2];
    assign o_velocity_x = r_out_vel[0];
    assign o_velocity_y = r_out_vel[1];
    assign o_velocity_z = r_out_vel[2];

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (!r_out_valid || !i_out_stall))
        else $error("result finished into an occupied output register");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("accepted word did not make the block busy");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |=> o_out_valid)
        else $error("finished word not presented on the output");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> w_sts.busy)
        else $error("completion without a word in flight");

endmodule

/* rtl/pis_mul.sv */
// Shared signed 33x33 multiplier with registered product and Q16.16 rounding.
// Depends on pis_pkg.
module pis_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  pis_pkg::t_opnd i_a,
    input  pis_pkg::t_opnd i_b,
    output pis_pkg::t_rnd  o_rnd
);
    import pis_pkg::*;

    logic signed [65:0] r_prod;
    logic signed [65:0] w_prod;
    logic signed [65:0] w_biased;

    assign w_prod   = i_a * i_b;
    assign w_biased = r_prod + 66'sd32768;
    assign o_rnd    = w_biased[65:16];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod;
        end
    end

endmodule

/* rtl/pis_core.sv */
// Sequencer, particle state and write-back datapath around one shared multiplier.
// Depends on pis_pkg and pis_mul.
module pis_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_kind,
    input  pis_pkg::t_word i_val [3],
    input  pis_pkg::t_cfg  i_cfg,
    input  logic           i_out_free,
    output pis_pkg::t_sts  o_sts,
    output pis_pkg::t_word o_pos [3],
    output pis_pkg::t_word o_vel [3]
);
    import pis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DT2,
        S_DT2_WB,
        S_ISSUE,
        S_WB,
        S_DONE
    } t_state;

    localparam logic [2:0] OP_ACC  = 3'd0;
    localparam logic [2:0] OP_ONE  = 3'd1;
    localparam logic [2:0] OP_TWO  = 3'd2;
    localparam logic [2:0] OP_THREE = 3'd3;
    localparam logic [2:0] OP_FOUR = 3'd4;

    t_state     r_st;
    logic [2:0] r_op;
    logic [1:0] r_ax;
    logic       r_first;
    t_word      r_pos [3];
    t_word      r_prev [3];
    t_word      r_vel [3];
    t_word      r_f [3];
    t_word      r_acc;
    t_word      r_dt2;
    t_word      r_term;
    t_word      r_older;
    t_word      r_diff;
    t_sum       r_sum;

    t_opnd      w_a;
    t_opnd      w_b;
    logic       w_mul_en;
    t_rnd       w_rnd;
    t_word      w_rsat;
    t_word      w_pos;
    t_word      w_vel;
    t_word      w_prev;
    t_word      w_add_pos;
    t_word      w_add_vel;
    t_word      w_older_first;
    t_sum       w_sum_a;
    t_sum       w_sum_b;
    t_word      w_pnew;
    t_word      w_diff;
    logic [2:0] w_last;

    assign w_pos  = r_pos[r_ax];
    assign w_vel  = r_vel[r_ax];
    assign w_prev = r_prev[r_ax];
    assign w_last = (i_cfg.method == METH_VERLET) ? OP_FOUR : OP_TWO;

    always_comb begin
        w_a      = '0;
        w_b      = '0;
        w_mul_en = 1'b0;
        unique case (r_st)
            S_DT2: begin
                w_mul_en = 1'b1;
                w_a      = $signed({16'b0, i_cfg.time_step});
                w_b      = $signed({16'b0, i_cfg.time_step});
            end
            S_ISSUE: begin
                w_mul_en = 1'b1;
                if (r_op == OP_ACC) begin
                    w_a = $signed({r_f[r_ax][31], r_f[r_ax]});
                    w_b = $signed({9'b0, i_cfg.inverse_mass});
                end else begin
                    unique case (i_cfg.method)
                        METH_EULER: begin
                            w_a = (r_op == OP_ONE) ? $signed({w_vel[31], w_vel})
                                                   : $signed({r_acc[31], r_acc});
                            w_b = $signed({16'b0, i_cfg.time_step});
                        end
                        METH_SEMI: begin
                            w_a = (r_op == OP_ONE) ? $signed({r_acc[31], r_acc})
                                                   : $signed({w_vel[31], w_vel});
                            w_b = $signed({16'b0, i_cfg.time_step});
                        end
                        default: begin
                            unique case (r_op)
                                OP_ONE: begin
                                    w_a = $signed({r_acc[31], r_acc});
                                    w_b = $signed({r_dt2[31], r_dt2});
                                end
                                OP_TWO: begin
                                    w_a = COEF_A;
                                    w_b = $signed({w_pos[31], w_pos});
                                end
                                OP_THREE: begin
                                    w_a = COEF_B;
                                    w_b = $signed({r_older[31], r_older});
                                end
                                default: begin
                                    w_a = $signed({r_diff[31], r_diff});
                                    w_b = $signed({2'b0, i_cfg.inverse_time_step});
                                end
                            endcase
                        end
                    endcase
                end
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    pis_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_rnd (w_rnd)
    );

    assign w_rsat        = f_sat(w_rnd);
    assign w_add_pos     = f_sat(f_ext32(w_pos) + f_ext32(w_rsat));
    assign w_add_vel     = f_sat(f_ext32(w_vel) + f_ext32(w_rsat));
    assign w_older_first = f_sat(f_ext32(w_pos) - f_ext32(w_rsat));
    assign w_sum_a       = w_rnd[35:0] + {{4{r_term[31]}}, r_term};
    assign w_sum_b       = r_sum - w_rnd[35:0];
    assign w_pnew        = f_sat(f_ext36(w_sum_b));
    assign w_diff        = f_sat(f_ext32(w_pnew) - f_ext32(w_pos));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_op    <= OP_ACC;
            r_ax    <= 2'd0;
            r_first <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_pos[k]  <= '0;
                r_prev[k] <= '0;
                r_vel[k]  <= '0;
            end
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_op <= OP_ACC;
                        r_ax <= 2'd0;
                        for (int k = 0; k < 3; k++) begin
                            r_f[k] <= i_val[k];
                        end
                        unique case (i_kind)
                            KIND_STEP: begin
                                if (i_cfg.method == METH_VERLET) begin
                                    r_st <= S_DT2;
                                end else if (i_cfg.method == METH_EULER ||
                                             i_cfg.method == METH_SEMI) begin
                                    r_st <= S_ISSUE;
                                end else begin
                                    r_st <= S_DONE;
                                end
                            end
                            KIND_LOAD_POS: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_pos[k]  <= i_val[k];
                                    r_prev[k] <= i_val[k];
                                end
                                r_st <= S_DONE;
                            end
                            KIND_LOAD_VEL: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_vel[k] <= i_val[k];
                                end
                                r_st <= S_DONE;
                            end
                            default: begin
                                r_st <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DT2: begin
                    r_st <= S_DT2_WB;
                end
                S_DT2_WB: begin
                    r_dt2 <= w_rsat;
                    r_st  <= S_ISSUE;
                end
                S_ISSUE: begin
                    r_st <= S_WB;
                end
                S_WB: begin
                    if (r_op == OP_ACC) begin
                        r_acc <= w_rsat;
                    end else begin
                        unique case (i_cfg.method)
                            METH_EULER: begin
                                if (r_op == OP_ONE) begin
                                    r_prev[r_ax] <= w_pos;
                                    r_pos[r_ax]  <= w_add_pos;
                                end else begin
                                    r_vel[r_ax] <= w_add_vel;
                                end
                            end
                            METH_SEMI: begin
                                if (r_op == OP_ONE) begin
                                    r_vel[r_ax] <= w_add_vel;
                                end else begin
                                    r_prev[r_ax] <= w_pos;
                                    r_pos[r_ax]  <= w_add_pos;
                                end
                            end
                            default: begin
                                unique case (r_op)
                                    OP_ONE: begin
                                        r_term  <= w_rsat;
                                        r_older <= r_first ? w_older_first : w_prev;
                                    end
                                    OP_TWO: begin
                                        r_sum <= w_sum_a;
                                    end
                                    OP_THREE: begin
                                        r_prev[r_ax] <= w_pos;
                                        r_pos[r_ax]  <= w_pnew;
                                        r_diff       <= w_diff;
                                    end
                                    default: begin
                                        r_vel[r_ax] <= w_rsat;
                                    end
                                endcase
                            end
                        endcase
                    end
                    if (r_op == w_last) begin
                        r_op <= OP_ACC;
                        if (r_ax == 2'd2) begin
                            r_st <= S_DONE;
                            if (i_cfg.method == METH_VERLET) begin
                                r_first <= 1'b0;
                            end
                        end else begin
                            r_ax <= r_ax + 2'd1;
                            r_st <= S_ISSUE;
                        end
                    end else begin
                        r_op <= r_op + 3'd1;
                        r_st <= S_ISSUE;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.busy = (r_st != S_IDLE);
    assign o_sts.done = (r_st == S_DONE) && i_out_free;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_pos[k] = r_pos[k];
            o_vel[k] = r_vel[k];
        end
    end

endmodule
